[rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned SampleW       = 32;
  localparam int unsigned CfgW          = 7;
  localparam int unsigned WindowMaxDflt = 64;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [CfgW-1:0]    cfg_t;

endpackage

[rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the running-maximum chain: holds the maximum of the newest
// samples over its depth and hands it to the next cell.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  logic    started_i,
  input  sample_t sample_i,
  input  sample_t prev_i,
  output sample_t max_o
);

  sample_t max_q;
  sample_t max_d;

  // A fresh array ignores whatever the neighbor still holds.
  always_comb begin
    max_d = sample_i;
    if (started_i && (prev_i > sample_i)) begin
      max_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

[rtl/swm_select.sv]
// ----------------------------------------------------------------------------
// swm_select
// Picks the chain cell whose depth equals the live deque length.
// ----------------------------------------------------------------------------
module swm_select
  import swm_pkg::*;
#(
  parameter int unsigned WindowMax = WindowMaxDflt,
  parameter int unsigned IdxW      = (WindowMax > 1) ? $clog2(WindowMax) : 1
) (
  input  sample_t         cells_i [WindowMax],
  input  logic [IdxW-1:0] idx_i,
  output sample_t         pick_o
);

  // AND-OR pick: every cell compares its own depth against the index.
  always_comb begin
    pick_o = '0;
    for (int unsigned k = 0; k < WindowMax; k++) begin
      if (idx_i == IdxW'(k)) begin
        pick_o = pick_o | cells_i[k];
      end
    end
  end

endmodule

[rtl/sliding_window_maximum.sv]
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Sliding window maximum over a stream of signed sample arrays, built as a
// chain of running-maximum cells plus a depth select.
//
//   channel   direction   handshake               payload
//   in        sink        in_valid_i/in_ready_o   sample_i, last_of_array_i
//   out       source      out_valid_o/out_ready_i window_max_o, last_result_o
//   cfg       sink        cfg_we_i                cfg_wdata_i (window_size)
//
// One sample per cycle is taken while the output is not stalled; each result
// passes the cell chain update, then the depth select into the output register.
// Cell k holds the maximum of the newest k+1 samples of the current array.
// Reset leaves the window size at 1 and the array state empty.
// A stalled output holds the select stage, which in turn holds the input.
// ----------------------------------------------------------------------------
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned WindowMax = WindowMaxDflt
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  cfg_t    cfg_wdata_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t sample_i,
  input  logic    last_of_array_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t window_max_o,
  output logic    last_result_o
);

  localparam int unsigned IdxW = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned CntW = $clog2(WindowMax + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;

  localparam logic [CmpW-1:0] WinMax = CmpW'(WindowMax);

  cfg_t            window_size_q;
  logic            started_q;
  logic [CntW-1:0] live_q;
  logic [CntW-1:0] seen_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            pend_last_q;
  logic            out_valid_q;
  sample_t         out_max_q;
  logic            out_last_q;

  logic            in_xfer;
  logic            sel_fire;
  logic [CmpW-1:0] win;
  logic [CmpW-1:0] span;
  logic [CmpW-1:0] live_inc;
  logic [CmpW-1:0] live_d;
  logic [CmpW-1:0] seen_d;
  logic            produce;
  sample_t         cells [WindowMax];
  sample_t         pick;

  // Clamp the window to the chain length; a zero window runs one wide.
  always_comb begin
    win = CmpW'(window_size_q);
    if (win > WinMax) begin
      win = WinMax;
    end
    span = (win == '0) ? CmpW'(1) : win;
  end

  // Live deque length grows by one per sample and never exceeds the span,
  // so entries dropped by a narrower window stay dropped.
  always_comb begin
    live_inc = CmpW'(live_q) + CmpW'(1);
    live_d   = (live_inc > span) ? span : live_inc;
    seen_d   = (CmpW'(seen_q) == WinMax) ? CmpW'(seen_q) : CmpW'(seen_q) + CmpW'(1);
    produce  = (win != '0) && (seen_d >= win);
  end

  assign sel_fire   = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || sel_fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  for (genvar k = 0; k < WindowMax; k++) begin : g_cell
    sample_t prev;
    if (k == 0) begin : g_head
      assign prev = sample_i;
    end else begin : g_link
      assign prev = cells[k-1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (in_xfer),
      .started_i(started_q),
      .sample_i (sample_i),
      .prev_i   (prev),
      .max_o    (cells[k])
    );
  end

  swm_select #(
    .WindowMax(WindowMax),
    .IdxW     (IdxW)
  ) u_select (
    .cells_i(cells),
    .idx_i  (pend_idx_q),
    .pick_o (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= cfg_t'(1);
      started_q     <= 1'b0;
      live_q        <= '0;
      seen_q        <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_size_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        pend_q <= produce;
        // Drop all array state after its last sample.
        if (last_of_array_i) begin
          started_q <= 1'b0;
          live_q    <= '0;
          seen_q    <= '0;
        end else begin
          started_q <= 1'b1;
          live_q    <= live_d[CntW-1:0];
          seen_q    <= seen_d[CntW-1:0];
        end
      end else if (sel_fire) begin
        pend_q <= 1'b0;
      end
      if (sel_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_idx_q  <= IdxW'(live_d - CmpW'(1));
      pend_last_q <= last_of_array_i;
    end
    if (sel_fire) begin
      out_max_q  <= pick;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_max_o  = out_max_q;
  assign last_result_o = out_last_q;

endmodule

[tb/sv/tb_sliding_window_maximum.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum
// Self-checking testbench for the sliding window maximum block. A tracker
// keeps its own candidate deque per array and queues the expected window
// maximum for each accepted sample that fills the window. Each output transfer is checked
// against the oldest queued maximum. Directed arrays cover the extreme
// samples, ties, short arrays, window sizes zero, one and above the maximum,
// and a window change in the middle of an array. Random arrays with random
// gaps and output stalls follow, under several window sizes.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;
  import swm_pkg::*;

  localparam int unsigned DequeDepth = 64;
  localparam int unsigned RandItems  = 500;
  localparam int unsigned QuietAfter = 440;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned CycleLimit = 200000;

  localparam sample_t SampleMax = 32'sh7FFF_FFFF;
  localparam sample_t SampleMin = 32'sh8000_0000;

  class window_max_tracker;
    typedef struct packed {
      sample_t max_val;
      logic    last;
    } max_entry_t;

    cfg_t       window_size = cfg_t'(1);
    sample_t    cand_vals[$];
    logic [6:0] cand_pos[$];
    logic [6:0] next_pos = '0;
    int         seen = 0;
    max_entry_t max_queue[$];
    int         errors = 0;

    function void set_window(cfg_t value);
      window_size = value;
    endfunction

    function int pending();
      return max_queue.size();
    endfunction

    function void take_sample(sample_t s, logic last);
      int         w;
      int         span;
      logic [6:0] age;
      max_entry_t entry;
      w    = (window_size > DequeDepth) ? DequeDepth : int'(window_size);
      span = (w == 0) ? 1 : w;
      // drop candidates that have left the window
      while (cand_vals.size() > 0) begin
        age = next_pos - cand_pos[0];
        if (int'(age) < span) break;
        cand_vals.delete(0);
        cand_pos.delete(0);
      end
      // drop tail entries that the new sample dominates, ties included
      while (cand_vals.size() > 0 && cand_vals[$] <= s) begin
        cand_vals.delete(cand_vals.size() - 1);
        cand_pos.delete(cand_pos.size() - 1);
      end
      if (cand_vals.size() < DequeDepth) begin
        cand_vals.insert(cand_vals.size(), s);
        cand_pos.insert(cand_pos.size(), next_pos);
      end
      if (seen < DequeDepth) seen++;
      next_pos = next_pos + 7'd1;
      if (w != 0 && seen >= w) begin
        entry.max_val = cand_vals[0];
        entry.last    = last;
        max_queue.insert(max_queue.size(), entry);
      end
      if (last) begin
        cand_vals.delete();
        cand_pos.delete();
        next_pos = '0;
        seen     = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_max(sample_t max_val, logic last);
      max_entry_t entry;
      if (max_queue.size() == 0) begin
        report($sformatf("unexpected result max=%0d last=%0b", max_val, last));
      end else begin
        entry = max_queue[0];
        max_queue.delete(0);
        if (max_val !== entry.max_val)
          report($sformatf("window_max got %0d want %0d", max_val, entry.max_val));
        if (last !== entry.last)
          report($sformatf("last_result got %0b want %0b", last, entry.last));
      end
    endtask
  endclass

  logic    clk_i           = 1'b0;
  logic    rst_ni          = 1'b0;
  logic    cfg_we_i        = 1'b0;
  cfg_t    cfg_wdata_i     = '0;
  logic    in_valid_i      = 1'b0;
  logic    in_ready_o;
  sample_t sample_i        = '0;
  logic    last_of_array_i = 1'b0;
  logic    out_valid_o;
  logic    out_ready_i     = 1'b0;
  sample_t window_max_o;
  logic    last_result_o;

  window_max_tracker tracker = new;
  logic              quiet      = 1'b0;
  int                stall_left = 0;
  int unsigned       cycles     = 0;
  int unsigned       rand_sent  = 0;

  sliding_window_maximum i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .last_of_array_i(last_of_array_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .window_max_o   (window_max_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // note every input transfer and check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.take_sample(sample_i, last_of_array_i);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_max(window_max_o, last_result_o);
  end

  // receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task send_sample(sample_t s, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= s;
    last_of_array_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the input until everything has drained, then write the window size
  task set_window_size(cfg_t value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tracker.set_window(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? SampleMax : SampleMin;
      1, 2, 3: return sample_t'($signed($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_window(int k);
    case (k)
      0:       return cfg_t'(1);
      1:       return cfg_t'(64);
      2:       return cfg_t'(0);
      3:       return cfg_t'(127);
      4:       return cfg_t'(2);
      default: begin
        if ($urandom_range(0, 3) == 0) return cfg_t'($urandom_range(0, 127));
        return cfg_t'($urandom_range(1, 8));
      end
    endcase
  endfunction

  // descending arrays fill the deque deep
  task send_array(int len, logic close);
    logic    falling;
    sample_t s;
    falling = ($urandom_range(0, 3) == 0);
    s       = sample_t'($urandom_range(0, 1000000));
    for (int i = 0; i < len; i++) begin
      if (falling) s = s - sample_t'($urandom_range(0, 2));
      else         s = pick_sample();
      send_sample(s, close && (i == len - 1));
      rand_sent++;
      if (rand_sent >= QuietAfter) quiet = 1'b1;
    end
  endtask

  initial begin
    cfg_t        w;
    int          eff;
    int          len;
    int unsigned budget;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window of one after reset: extremes pass straight through
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b1);

    // ties keep the newest, then an array shorter than the window
    set_window_size(cfg_t'(3));
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(2, 1'b1);
    send_sample(1, 1'b0);
    send_sample(2, 1'b1);

    // zero window gives nothing
    set_window_size(cfg_t'(0));
    send_sample(3, 1'b0);
    send_sample(1, 1'b1);

    // oversized window clamps to the deque depth
    set_window_size(cfg_t'(100));
    send_sample(7, 1'b0);
    send_sample(8, 1'b0);
    send_sample(9, 1'b1);

    // grow the window in the middle of an array
    set_window_size(cfg_t'(2));
    send_sample(1, 1'b0);
    send_sample(9, 1'b0);
    send_sample(4, 1'b0);
    set_window_size(cfg_t'(4));
    send_sample(3, 1'b0);
    send_sample(2, 1'b1);

    set_window_size(cfg_t'(127));
    send_sample(-5, 1'b1);

    for (int phase = 0; rand_sent < RandItems; phase++) begin
      w = pick_window(phase);
      set_window_size(w);
      eff    = (w > DequeDepth) ? DequeDepth : ((w == 0) ? 4 : int'(w));
      budget = rand_sent + 60;
      while (rand_sent < budget && rand_sent < RandItems) begin
        if (eff <= 8 && $urandom_range(0, 15) == 0) len = $urandom_range(130, 180);
        else                                        len = $urandom_range(1, eff + 12);
        // keep the item count near the planned total
        if (len > int'(RandItems - rand_sent)) len = int'(RandItems - rand_sent);
        // an unclosed array runs on into the next one
        send_array(len, $urandom_range(0, 7) != 0);
      end
    end

    quiet      = 1'b1;
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_select.sv
rtl/sliding_window_maximum.sv
tb/sv/tb_sliding_window_maximum.sv
